// ----- sv/dts_pkg.sv -----
// Shared types and constants for the deadline timer slot table.
// Used by every module of the block except dts_ram; depends on nothing.
`default_nettype none
package dts_pkg;
	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int DL_W = 64;
	localparam int DELAY_W = 32;
	localparam int CPU_W = 10;
	localparam int FUNC_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [FUNC_W-1:0] FN_ADD = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_TICK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RUNNING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCKS_PER_US = 1'd1;

	localparam logic [1:0] LOP_NONE = 2'd0;
	localparam logic [1:0] LOP_UNLINK = 2'd1;
	localparam logic [1:0] LOP_APPEND = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [3:0] slot;
		logic [DELAY_W-1:0] delay_us;
		logic [DL_W-1:0] now;
	} req_t;

	typedef struct packed {
		logic status;
		logic fired_valid;
		logic [3:0] fired_slot;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [1:0] op;
		logic [SLOT_W-1:0] slot;
	} list_cmd_t;

	typedef struct packed {
		logic [SLOTS-1:0] armed;
		logic [SLOT_W-1:0] next_at;
		logic [SLOT_W-1:0] head;
		logic [CNT_W-1:0] count;
	} list_stat_t;
endpackage
`default_nettype wire

// ----- sv/deadline_timer_slots.sv -----
// Deadline timer slot table: sixteen 64-bit deadlines in insertion order.
// Depends on dts_pkg, dts_ram, dts_addsub and dts_list.
//
// Requests enter on req (valid/ready); results leave on rsp (valid/ready).
// A request is taken only while the sequencer is idle, so one request is in
// work at a time. Add computes delay_us * clocks_per_us by shift-and-add on
// the shared 64-bit adder, one multiplier bit a cycle until the remaining
// bits are zero, then adds now with the same adder and links the slot. A
// tick reads one deadline a cycle from the deadline RAM, except while it
// stalls on the output, compares it on the adder and follows the list.
// Each tick gives one result per expired slot, or a single result when
// none expired; the final result of every request carries last.
// One fired slot is held back until the next one is found, so last can be
// set on the true final result. A single output register holds results;
// while the receiver stalls, the sequencer waits only when it has a new
// result to place there. Reset disarms all slots, stops the service and
// sets clocks_per_us to 37; configuration writes are taken at once.
`default_nettype none
module deadline_timer_slots (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire dts_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output dts_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [dts_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [dts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dts_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_ADD = 3'd2;
	localparam logic [2:0] S_APPEND = 3'd3;
	localparam logic [2:0] S_UNLINK = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;
	localparam logic [2:0] S_TICK = 3'd6;
	localparam logic [2:0] S_TEND = 3'd7;

	logic [2:0] state_q;
	logic running_q;
	logic [CPU_W-1:0] clocks_per_us_q;
	logic status_q;
	logic pend_valid_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [SLOT_W-1:0] slot_q;
	logic [DL_W-1:0] now_q;
	logic [DL_W-1:0] acc_q;
	logic [DL_W-1:0] mcand_q;
	logic [CPU_W-1:0] mlt_q;
	logic [SLOT_W-1:0] cur_q;
	logic [CNT_W-1:0] left_q;

	logic accept;
	logic slot_ok;
	logic out_free;
	logic fire;
	logic tick_stall;
	logic emit;
	rsp_t emit_rsp;
	list_cmd_t list_cmd;
	list_stat_t stat;
	logic [DL_W-1:0] alu_a;
	logic [DL_W-1:0] alu_b;
	logic alu_sub;
	logic [DL_W-1:0] alu_sum;
	logic alu_carry;
	logic ram_we;
	logic [SLOT_W-1:0] ram_raddr;
	logic [DL_W-1:0] ram_rdata;

	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign slot_ok = (32'(req.slot) < SLOTS);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign fire = (state_q == S_TICK) && stat.armed[cur_q] && alu_carry;
	assign tick_stall = fire && pend_valid_q && !out_free;
	assign ram_we = (state_q == S_ADD);

	always_comb begin
		list_cmd.op = LOP_NONE;
		list_cmd.slot = (state_q == S_TICK) ? cur_q : slot_q;
		case (state_q)
			S_ADD, S_UNLINK: begin
				if (stat.armed[slot_q]) begin
					list_cmd.op = LOP_UNLINK;
				end
			end
			S_APPEND: begin
				list_cmd.op = LOP_APPEND;
			end
			S_TICK: begin
				if (fire && !tick_stall) begin
					list_cmd.op = LOP_UNLINK;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		alu_a = now_q;
		alu_b = ram_rdata;
		alu_sub = 1'b1;
		case (state_q)
			S_MUL: begin
				alu_a = acc_q;
				alu_b = mlt_q[0] ? mcand_q : '0;
				alu_sub = 1'b0;
			end
			S_ADD: begin
				alu_b = acc_q;
				alu_sub = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// The deadline of the next slot is fetched while the current one is judged.
	always_comb begin
		case (state_q)
			S_IDLE: ram_raddr = stat.head;
			S_TICK: ram_raddr = tick_stall ? cur_q : stat.next_at;
			default: ram_raddr = cur_q;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		emit_rsp = '{status: status_q, fired_valid: 1'b0, fired_slot: '0, last: 1'b1};
		case (state_q)
			S_RESP: begin
				emit = out_free;
			end
			S_TICK: begin
				emit = fire && pend_valid_q && out_free;
				emit_rsp = '{status: 1'b0, fired_valid: 1'b1, fired_slot: pend_slot_q,
					last: 1'b0};
			end
			S_TEND: begin
				emit = out_free;
				emit_rsp = '{status: 1'b0, fired_valid: pend_valid_q,
					fired_slot: pend_valid_q ? pend_slot_q : '0, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	dts_addsub u_addsub (
		.a(alu_a),
		.b(alu_b),
		.sub(alu_sub),
		.sum(alu_sum),
		.carry(alu_carry)
	);

	dts_ram #(
		.WIDTH(DL_W),
		.DEPTH(SLOTS)
	) u_deadline_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(slot_q),
		.wdata(alu_sum),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dts_list u_list (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(list_cmd),
		.stat(stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			running_q <= 1'b0;
			clocks_per_us_q <= CPU_W'(37);
			status_q <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RUNNING: running_q <= cfg_data[0];
					CFG_CLOCKS_PER_US: clocks_per_us_q <= cfg_data[CPU_W-1:0];
					default: begin
					end
				endcase
			end

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= !running_q;
						if (!running_q) begin
							state_q <= S_RESP;
						end else if (req.func == FN_ADD && slot_ok) begin
							state_q <= S_MUL;
						end else if (req.func == FN_REMOVE && slot_ok) begin
							state_q <= S_UNLINK;
						end else if (req.func == FN_TICK) begin
							state_q <= (stat.count == '0) ? S_TEND : S_TICK;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_MUL: begin
					if (mlt_q == '0) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: state_q <= S_APPEND;
				S_APPEND: state_q <= S_RESP;
				S_UNLINK: state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (!tick_stall) begin
						if (fire) begin
							pend_valid_q <= 1'b1;
						end
						if (left_q == CNT_W'(1)) begin
							state_q <= S_TEND;
						end
					end
				end
				S_TEND: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
		if (accept) begin
			slot_q <= req.slot[SLOT_W-1:0];
			now_q <= req.now;
			mcand_q <= DL_W'(req.delay_us);
			mlt_q <= clocks_per_us_q;
			acc_q <= '0;
			cur_q <= stat.head;
			left_q <= stat.count;
		end
		if (state_q == S_MUL && mlt_q != '0) begin
			acc_q <= alu_sum;
			mlt_q <= mlt_q >> 1;
			mcand_q <= mcand_q << 1;
		end
		if (state_q == S_TICK && !tick_stall) begin
			left_q <= left_q - CNT_W'(1);
			cur_q <= stat.next_at;
			if (fire) begin
				pend_slot_q <= cur_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count == CNT_W'($countones(stat.armed)))
		else $error("armed count disagrees with armed flags");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count == '0 |-> stat.head == '0)
		else $error("empty list does not point at slot zero");

	a_no_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !pend_valid_q)
		else $error("held fired slot survived the end of a tick");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fired_valid |-> !rsp.status)
		else $error("fired slot reported with not-running status");
endmodule
`default_nettype wire

// ----- sv/dts_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module dts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/dts_addsub.sv -----
// Shared 64-bit adder of the timer block: add, or subtract with carry out
// as an unsigned greater-or-equal flag. Depends on dts_pkg.
`default_nettype none
module dts_addsub (
	input wire logic [dts_pkg::DL_W-1:0] a,
	input wire logic [dts_pkg::DL_W-1:0] b,
	input wire logic sub,
	output logic [dts_pkg::DL_W-1:0] sum,
	output logic carry
);
	import dts_pkg::*;

	logic [DL_W-1:0] b_eff;
	logic [DL_W:0] full;

	// With sub set, carry out is high exactly when a >= b.
	assign b_eff = sub ? ~b : b;
	assign full = {1'b0, a} + {1'b0, b_eff} + (DL_W + 1)'(sub);
	assign sum = full[DL_W-1:0];
	assign carry = full[DL_W];
endmodule
`default_nettype wire

// ----- sv/dts_list.sv -----
// Armed flags and the doubly linked insertion-order list of timer slots.
// Performs one unlink or one append per cycle. Depends on dts_pkg.
`default_nettype none
module dts_list (
	input wire logic clk,
	input wire logic arst_n,
	input wire dts_pkg::list_cmd_t cmd,
	output dts_pkg::list_stat_t stat
);
	import dts_pkg::*;

	logic [SLOTS-1:0] armed_q;
	logic [SLOT_W-1:0] next_q [SLOTS];
	logic [SLOT_W-1:0] prev_q [SLOTS];
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] s;
	logic [SLOT_W-1:0] n;
	logic [SLOT_W-1:0] p;
	logic [CNT_W-1:0] cnt_dec;

	assign s = cmd.slot;
	assign n = next_q[s];
	assign p = prev_q[s];
	assign cnt_dec = (cnt_q != '0) ? cnt_q - CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				LOP_UNLINK: begin
					if (s == head_q) begin
						head_q <= n;
					end
					if (s == tail_q) begin
						tail_q <= p;
					end
					armed_q[s] <= 1'b0;
					cnt_q <= cnt_dec;
					// An empty list always points at slot zero.
					if (cnt_dec == '0) begin
						head_q <= '0;
						tail_q <= '0;
					end
				end
				LOP_APPEND: begin
					if (cnt_q == '0) begin
						head_q <= s;
					end
					tail_q <= s;
					armed_q[s] <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			LOP_UNLINK: begin
				if (s != head_q) begin
					next_q[p] <= n;
				end
				if (s != tail_q) begin
					prev_q[n] <= p;
				end
			end
			LOP_APPEND: begin
				if (cnt_q == '0) begin
					prev_q[s] <= '0;
				end else begin
					next_q[tail_q] <= s;
					prev_q[s] <= tail_q;
				end
				next_q[s] <= '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.armed = armed_q;
	assign stat.next_at = n;
	assign stat.head = head_q;
	assign stat.count = cnt_q;
endmodule
`default_nettype wire

// ----- bench/timer_list_checker.sv -----
`timescale 1ns / 1ps
// Checker for deadline_timer_slots: keeps its own copy of the slot table and of
// the insertion-order list, predicts every result and compares it with the block.
// Depends on dts_pkg; instantiated beside the block by tb_top.
module timer_list_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input dts_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input dts_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [dts_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [dts_pkg::CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int waiting,
	output int checked,
	output int fired
);
	import dts_pkg::*;

	rsp_t pending_rsp[$];
	rsp_t want;
	logic running_q;
	logic [CPU_W-1:0] cpu_q;
	logic [DL_W-1:0] due_at [SLOTS];
	logic slot_on [SLOTS];
	logic [SLOT_W-1:0] next_of [SLOTS];
	logic [SLOT_W-1:0] prev_of [SLOTS];
	logic [SLOT_W-1:0] oldest;
	logic [SLOT_W-1:0] newest;
	int live;

	function automatic rsp_t result_of(logic st, logic fv, logic [3:0] fs, logic lst);
		rsp_t o;
		o.status = st;
		o.fired_valid = fv;
		o.fired_slot = fs;
		o.last = lst;
		return o;
	endfunction

	function automatic void unlink(logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] n;
		logic [SLOT_W-1:0] p;
		n = next_of[s];
		p = prev_of[s];
		if (s == oldest)
			oldest = n;
		else
			next_of[p] = n;
		if (s == newest)
			newest = p;
		else
			prev_of[n] = p;
		slot_on[s] = 1'b0;
		if (live > 0)
			live--;
		if (live == 0) begin
			oldest = '0;
			newest = '0;
		end
	endfunction

	function automatic void append(logic [SLOT_W-1:0] s);
		if (live == 0) begin
			oldest = s;
			newest = s;
			prev_of[s] = '0;
		end else begin
			next_of[newest] = s;
			prev_of[s] = newest;
			newest = s;
		end
		next_of[s] = '0;
		slot_on[s] = 1'b1;
		live++;
	endfunction

	// Applies one accepted request to the table and queues the results it causes.
	function automatic void serve_request(req_t r);
		logic [SLOT_W-1:0] cur;
		logic [SLOT_W-1:0] nx;
		int left;
		rsp_t held;
		bit have_held;
		have_held = 1'b0;
		if (!running_q) begin
			pending_rsp.push_back(result_of(1'b1, 1'b0, 4'd0, 1'b1));
			return;
		end
		if (r.func == FN_TICK) begin
			cur = oldest;
			left = live;
			// A tick can fire at most one result per slot.
			while (left > 0) begin
				nx = next_of[cur];
				left--;
				if (slot_on[cur] && r.now >= due_at[cur]) begin
					unlink(cur);
					// Hold each fired slot back until we know whether it is the last one.
					if (have_held)
						pending_rsp.push_back(held);
					held = result_of(1'b0, 1'b1, cur, 1'b0);
					have_held = 1'b1;
					fired++;
				end
				cur = nx;
			end
			if (have_held) begin
				held.last = 1'b1;
				pending_rsp.push_back(held);
			end else begin
				pending_rsp.push_back(result_of(1'b0, 1'b0, 4'd0, 1'b1));
			end
			return;
		end
		if (r.func == FN_ADD) begin
			if (slot_on[r.slot])
				unlink(r.slot);
			due_at[r.slot] = r.now + DL_W'(r.delay_us) * DL_W'(cpu_q);
			append(r.slot);
		end else if (r.func == FN_REMOVE && slot_on[r.slot]) begin
			unlink(r.slot);
		end
		pending_rsp.push_back(result_of(1'b0, 1'b0, 4'd0, 1'b1));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q = 1'b0;
			cpu_q = 10'd37;
			live = 0;
			oldest = '0;
			newest = '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_on[i] = 1'b0;
				due_at[i] = '0;
				next_of[i] = '0;
				prev_of[i] = '0;
			end
			pending_rsp.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RUNNING: running_q = cfg_data[0];
					CFG_CLOCKS_PER_US: cpu_q = cfg_data[CPU_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				serve_request(req);
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, nothing expected;", $time,
						" got status %0b fired %0b slot %0d last %0b",
						rsp.status, rsp.fired_valid, rsp.fired_slot, rsp.last);
				end else begin
					want = pending_rsp.pop_front();
					checked++;
					if (rsp.status !== want.status || rsp.fired_valid !== want.fired_valid ||
							rsp.fired_slot !== want.fired_slot || rsp.last !== want.last) begin
						errors++;
						$display("%0t: mismatch: expected status %0b fired %0b slot %0d last %0b,",
							$time, want.status, want.fired_valid, want.fired_slot, want.last,
							" got status %0b fired %0b slot %0d last %0b",
							rsp.status, rsp.fired_valid, rsp.fired_slot, rsp.last);
					end
				end
			end
		end
		waiting = pending_rsp.size();
	end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the deadline_timer_slots bench: clock, reset, request and register
// stimulus, receiver back-pressure and the final verdict.
// Depends on dts_pkg, deadline_timer_slots and timer_list_checker.
module tb_top;
	import dts_pkg::*;

	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_RUNNING;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int waiting;
	int checked;
	int fired;
	int idle_pct = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycles = 0;
	logic [DL_W-1:0] clock_now = '0;
	logic [DL_W-1:0] cpu_step = 64'd37;

	always #6 clk = ~clk;

	deadline_timer_slots uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	timer_list_checker list_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.errors(errors),
		.waiting(waiting),
		.checked(checked),
		.fired(fired)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycles, waiting);
			$display("deadline_timer_slots test failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
	always @(negedge clk) begin
		if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready = 1'b0;
		end else begin
			rsp_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic req_t request_of(logic [FUNC_W-1:0] f, logic [3:0] s,
			logic [DELAY_W-1:0] d, logic [DL_W-1:0] t);
		req_t r;
		r.func = f;
		r.slot = s;
		r.delay_us = d;
		r.now = t;
		return r;
	endfunction

	// Offers one item, with random gaps before it; returns at the falling edge after acceptance.
	task automatic send(req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int pick;
		int count;
		logic run_set;
		logic [CPU_W-1:0] cpu_set;
		req_t r;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The service is stopped after reset, so every request is refused.
		send(request_of(FN_ADD, 4'd3, 32'd5, 64'd0));
		send(request_of(FN_REMOVE, 4'd3, '0, '0));
		send(request_of(FN_TICK, 4'd0, '0, '1));
		send(request_of(FN_SPARE, 4'd15, '1, '0));

		set_reg(CFG_CLOCKS_PER_US, 10'd37);
		set_reg(CFG_RUNNING, 10'd1);
		send(request_of(FN_ADD, 4'd0, 32'd0, 64'd0));
		// This deadline wraps past the top of the 64-bit range.
		send(request_of(FN_ADD, 4'd15, '1, '1));
		send(request_of(FN_ADD, 4'd7, 32'd1, 64'd100));
		send(request_of(FN_ADD, 4'd0, 32'd2, 64'd0));
		send(request_of(FN_REMOVE, 4'd3, '0, '0));
		send(request_of(FN_SPARE, 4'd7, 32'd9, 64'd9));
		send(request_of(FN_TICK, 4'd0, '0, 64'd73));
		send(request_of(FN_TICK, 4'd0, '0, 64'd74));
		send(request_of(FN_REMOVE, 4'd7, '0, '0));
		send(request_of(FN_TICK, 4'd0, '0, '1));
		send(request_of(FN_TICK, 4'd0, '0, '0));
		// With a zero rate the deadline is the add time itself.
		set_reg(CFG_CLOCKS_PER_US, 10'd0);
		send(request_of(FN_ADD, 4'd9, '1, 64'd500));
		send(request_of(FN_TICK, 4'd0, '0, 64'd499));
		send(request_of(FN_TICK, 4'd0, '0, 64'd500));

		for (int ph = 0; ph < PHASES; ph++) begin
			run_set = 1'b1;
			count = 55;
			case (ph)
				0: begin cpu_set = 10'd1; idle_pct = 0; stall_pct = 0; end
				1: begin cpu_set = 10'd1023; idle_pct = 70; stall_pct = 0; end
				2: begin cpu_set = 10'd0; idle_pct = 0; stall_pct = 70; end
				3: begin
					cpu_set = CPU_W'($urandom_range(1022, 2));
					idle_pct = 35;
					stall_pct = 35;
				end
				4: begin cpu_set = 10'd37; run_set = 1'b0; count = 20; idle_pct = 0; stall_pct = 0; end
				default: begin cpu_set = 10'd512; idle_pct = 35; stall_pct = 35; end
			endcase
			set_reg(CFG_CLOCKS_PER_US, cpu_set);
			set_reg(CFG_RUNNING, {9'($urandom_range(511)), run_set});
			cpu_step = (cpu_set == 0) ? 64'd1 : DL_W'(cpu_set);
			// The last phase runs close to the top of the time range so sums wrap.
			clock_now = (ph == PHASES - 1) ? 64'hFFFF_FFFF_FFFF_0000
				: {$urandom, $urandom} >> 1;
			// Long receiver hold-off while the sender keeps offering items back to back.
			if (ph == 0)
				holds_asked++;
			for (int k = 0; k < count; k++) begin
				pick = $urandom_range(99);
				r = request_of(FN_ADD, 4'($urandom_range(15)), DELAY_W'($urandom_range(40)),
					clock_now);
				if (pick < 3) begin
					// Arm every slot, then expire them all with a single tick.
					for (int s = 0; s < SLOTS; s++)
						send(request_of(FN_ADD, SLOT_W'(s), DELAY_W'($urandom_range(40)),
							clock_now));
					clock_now += 64'd41 * cpu_step;
					r = request_of(FN_TICK, 4'($urandom_range(15)), $urandom, clock_now);
				end else if (pick < 18) begin
					r.func = FN_REMOVE;
				end else if (pick < 46) begin
					clock_now += DL_W'($urandom_range(25)) * cpu_step;
					r.func = FN_TICK;
					r.now = clock_now;
				end else if (pick < 50) begin
					r.func = FN_SPARE;
				end else if (pick < 60) begin
					r = request_of(FUNC_W'($urandom_range(3)), 4'($urandom_range(15)), $urandom,
						{$urandom, $urandom});
				end
				send(r);
			end
		end

		settle();
		repeat (24) @(negedge clk);
		$display("Sent %0d requests across six register and back-pressure settings.", items_sent);
		$display("Checked %0d results, %0d of them reporting an expired slot.", checked, fired);
		if (errors == 0 && waiting == 0)
			$display("deadline_timer_slots test passed");
		else
			$display("deadline_timer_slots test failed");
		$finish;
	end
endmodule

// ----- deadline_timer_slots.f -----
sv/dts_pkg.sv
sv/dts_ram.sv
sv/dts_addsub.sv
sv/dts_list.sv
sv/deadline_timer_slots.sv
bench/timer_list_checker.sv
bench/tb_top.sv
